@@ sv/ttcahd_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcahd_pkg
// Shared types, widths and register codes for the TTC alert block.
// ----------------------------------------------------------------------------
package ttcahd_pkg;

  typedef logic signed [15:0] sval16_t;
  typedef logic        [15:0] uval16_t;
  typedef logic        [1:0]  level_t;
  typedef logic signed [23:0] ttc_t;

  localparam int FRAME_STEP_MS_DEF = 50;

  localparam int TIMER_W  = 17;
  localparam int DVD_W    = 25;   // |pos| * 1000 < 2**25
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int ADDR_W   = 5;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam ttc_t TTC_MAX = 24'sh7FFFFF;
  localparam ttc_t TTC_MIN = 24'sh800000;
  localparam logic [DVD_W-1:0] MAG_MAX_POS = 25'd8388607;
  localparam logic [DVD_W-1:0] MAG_MAX_NEG = 25'd8388608;

  localparam level_t LVL_NONE = 2'd0;
  localparam level_t LVL_PRE  = 2'd1;
  localparam level_t LVL_WARN = 2'd2;
  localparam level_t LVL_EMG  = 2'd3;

  localparam logic [2:0] REG_SPEED_LOW   = 3'd0;
  localparam logic [2:0] REG_SPEED_HIGH  = 3'd1;
  localparam logic [2:0] REG_ENABLE_TTC  = 3'd2;
  localparam logic [2:0] REG_DISABLE_TTC = 3'd3;
  localparam logic [2:0] REG_DWELL       = 3'd4;
  localparam logic [2:0] REG_EMG_TTC     = 3'd5;
  localparam logic [2:0] REG_WARN_TTC    = 3'd6;
  localparam logic [2:0] REG_PRE_TTC     = 3'd7;

endpackage

@@ sv/ttcahd_ifs.sv @@
// ----------------------------------------------------------------------------
// ttcahd_in_if / ttcahd_out_if
// Valid/ready channels for radar frame beats and alert result beats.
// ----------------------------------------------------------------------------
interface ttcahd_in_if import ttcahd_pkg::*; ();
  logic    valid;
  logic    ready;
  sval16_t own_speed;
  sval16_t target_pos;
  sval16_t target_vel;

  modport source (output valid, own_speed, target_pos, target_vel, input ready);
  modport sink   (input valid, own_speed, target_pos, target_vel, output ready);
endinterface

interface ttcahd_out_if import ttcahd_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t warning_level;
  logic   alert_active;
  ttc_t   ttc_ms;

  modport source (output valid, warning_level, alert_active, ttc_ms, input ready);
  modport sink   (input valid, warning_level, alert_active, ttc_ms, output ready);
endinterface

@@ sv/ttc_alert_hysteresis_dwell.sv @@
// ----------------------------------------------------------------------------
// ttc_alert_hysteresis_dwell
// Time-to-collision alert with hysteresis thresholds, dwell timers and grading.
// ----------------------------------------------------------------------------
// Flow: an accepted beat passes the states MUL, DIV (the 25-step serial divider)
// and FIN; a new beat is taken only once its predecessor has left FIN.
// in ready is high only while the sequencer is idle; the output register lets
// the next beat enter while the previous result still waits to be taken.
// Reset (rst_n low, synchronous): alert flag and dwell timers cleared, config
// registers back to their defaults, no result pending.
// ----------------------------------------------------------------------------
module ttc_alert_hysteresis_dwell import ttcahd_pkg::*; #(
  parameter int FRAME_STEP_MS = FRAME_STEP_MS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ttcahd_in_if.sink           in_beat,
  ttcahd_out_if.source        out_beat,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;  // magnitudes and |pos|*1000
  localparam logic [1:0] ST_DIV  = 2'd2;  // one quotient bit per cycle
  localparam logic [1:0] ST_FIN  = 2'd3;  // sign, saturate, hysteresis, grade

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  sval16_t speed_low_r, speed_high_r;
  uval16_t enable_ttc_r, disable_ttc_r, dwell_r, emg_ttc_r, warn_ttc_r, pre_ttc_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_low_r   <= 16'sd0;
      speed_high_r  <= 16'sd32767;
      enable_ttc_r  <= 16'd2700;
      disable_ttc_r <= 16'd3000;
      dwell_r       <= 16'd200;
      emg_ttc_r     <= 16'd1200;
      warn_ttc_r    <= 16'd2000;
      pre_ttc_r     <= 16'd2700;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SPEED_LOW:   speed_low_r   <= cfg_pwdata[15:0];
        REG_SPEED_HIGH:  speed_high_r  <= cfg_pwdata[15:0];
        REG_ENABLE_TTC:  enable_ttc_r  <= cfg_pwdata[15:0];
        REG_DISABLE_TTC: disable_ttc_r <= cfg_pwdata[15:0];
        REG_DWELL:       dwell_r       <= cfg_pwdata[15:0];
        REG_EMG_TTC:     emg_ttc_r     <= cfg_pwdata[15:0];
        REG_WARN_TTC:    warn_ttc_r    <= cfg_pwdata[15:0];
        REG_PRE_TTC:     pre_ttc_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Signed registers read back sign-extended
  always_comb begin
    case (cfg_idx)
      REG_SPEED_LOW:   cfg_prdata = {{16{speed_low_r[15]}}, speed_low_r};
      REG_SPEED_HIGH:  cfg_prdata = {{16{speed_high_r[15]}}, speed_high_r};
      REG_ENABLE_TTC:  cfg_prdata = {16'd0, enable_ttc_r};
      REG_DISABLE_TTC: cfg_prdata = {16'd0, disable_ttc_r};
      REG_DWELL:       cfg_prdata = {16'd0, dwell_r};
      REG_EMG_TTC:     cfg_prdata = {16'd0, emg_ttc_r};
      REG_WARN_TTC:    cfg_prdata = {16'd0, warn_ttc_r};
      REG_PRE_TTC:     cfg_prdata = {16'd0, pre_ttc_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and shared divider
  // --------------------------------------------------------------------------
  logic [1:0]       state_r;
  logic [CNT_W-1:0] cnt_r;
  sval16_t          speed_r, pos_r, vel_r;     // captured beat
  logic [DVD_W-1:0] dvd_r;                     // dividend, quotient shifts in
  logic [15:0]      dsr_r;                     // |vel|
  logic [15:0]      rem_r;

  logic             alert_r;
  logic [TIMER_W-1:0] en_tmr_r, dis_tmr_r;

  logic             out_valid_r;
  level_t           out_level_r;
  logic             out_alert_r;
  ttc_t             out_ttc_r;

  logic             in_acc;
  logic             out_free;
  logic [15:0]      pos_mag, vel_mag;
  logic [16:0]      trial;
  logic             qbit;

  assign in_beat.ready = (state_r == ST_IDLE);
  assign in_acc        = in_beat.valid && in_beat.ready;
  assign out_free      = !out_valid_r || out_beat.ready;

  // 0x8000 negates to itself, which reads correctly as unsigned 32768
  assign pos_mag = pos_r[15] ? 16'(-pos_r) : pos_r;
  assign vel_mag = vel_r[15] ? 16'(-vel_r) : vel_r;

  // restoring step
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  // --------------------------------------------------------------------------
  // Final stage: sign, saturation, dwell timers, grading
  // --------------------------------------------------------------------------
  logic               skip, neg;
  ttc_t               ttc_c;
  logic signed [24:0] ttc_x;
  logic [TIMER_W-1:0] en_inc, dis_inc, dwell_x;
  logic               alert_nxt;
  logic [TIMER_W-1:0] en_tmr_nxt, dis_tmr_nxt;
  level_t             level_c;

  assign skip = (speed_r < speed_low_r) || (speed_r > speed_high_r) || (vel_r == 16'sd0);
  assign neg  = (pos_r != 16'sd0) && (vel_r != 16'sd0) && (pos_r[15] == vel_r[15]);

  always_comb begin
    if (skip) begin
      ttc_c = '0;
    end else if (neg) begin
      ttc_c = (dvd_r > MAG_MAX_NEG) ? TTC_MIN : 24'(~dvd_r + 25'd1);
    end else begin
      ttc_c = (dvd_r > MAG_MAX_POS) ? TTC_MAX : dvd_r[23:0];
    end
  end

  assign ttc_x   = {ttc_c[23], ttc_c};
  assign en_inc  = TIMER_W'(en_tmr_r + TIMER_W'(FRAME_STEP_MS));
  assign dis_inc = TIMER_W'(dis_tmr_r + TIMER_W'(FRAME_STEP_MS));
  assign dwell_x = {1'b0, dwell_r};

  always_comb begin
    alert_nxt   = alert_r;
    en_tmr_nxt  = en_tmr_r;
    dis_tmr_nxt = dis_tmr_r;
    if (skip) begin
      alert_nxt = 1'b0;               // timers hold
    end else if (!neg && ttc_x <= $signed({9'd0, enable_ttc_r})) begin
      dis_tmr_nxt = '0;
      en_tmr_nxt  = en_inc;
      if (en_inc >= dwell_x) begin
        en_tmr_nxt = dwell_x;
        alert_nxt  = 1'b1;
      end
    end else if (neg || ttc_x >= $signed({9'd0, disable_ttc_r})) begin
      en_tmr_nxt  = '0;
      dis_tmr_nxt = dis_inc;
      if (dis_inc >= dwell_x) begin
        dis_tmr_nxt = dwell_x;
        alert_nxt   = 1'b0;
      end
    end else begin
      en_tmr_nxt  = '0;
      dis_tmr_nxt = '0;
    end
  end

  // negative ttc grades as emergency while the flag is still up
  always_comb begin
    if (!alert_nxt)                                 level_c = LVL_NONE;
    else if (ttc_x <= $signed({9'd0, emg_ttc_r}))   level_c = LVL_EMG;
    else if (ttc_x <= $signed({9'd0, warn_ttc_r}))  level_c = LVL_WARN;
    else if (ttc_x <= $signed({9'd0, pre_ttc_r}))   level_c = LVL_PRE;
    else                                            level_c = LVL_NONE;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      alert_r     <= 1'b0;
      en_tmr_r    <= '0;
      dis_tmr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result beat replaces the one taken this cycle
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) state_r <= ST_MUL;
        end
        ST_MUL: begin
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            alert_r     <= alert_nxt;
            en_tmr_r    <= en_tmr_nxt;
            dis_tmr_r   <= dis_tmr_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      speed_r <= in_beat.own_speed;
      pos_r   <= in_beat.target_pos;
      vel_r   <= in_beat.target_vel;
    end
    if (state_r == ST_MUL) begin
      dvd_r <= DVD_W'(pos_mag) * DVD_W'(MS_PER_S);
      dsr_r <= vel_mag;
      rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= qbit ? 16'(trial - {1'b0, dsr_r}) : trial[15:0];
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
    end
    if (state_r == ST_FIN && out_free) begin
      out_level_r <= level_c;
      out_alert_r <= alert_nxt;
      out_ttc_r   <= ttc_c;
    end
  end

  assign out_beat.valid         = out_valid_r;
  assign out_beat.warning_level = out_level_r;
  assign out_beat.alert_active  = out_alert_r;
  assign out_beat.ttc_ms        = out_ttc_r;

endmodule
